// ===== design/mffd_pkg.sv =====
// shared types and constants for the message frame field deframer
package mffd_pkg;

  // result kinds
  typedef enum logic [2:0] {
    KIND_SUBJECT   = 3'd0,
    KIND_SENDER    = 3'd1,
    KIND_CONTENT   = 3'd2,
    KIND_DELIVERED = 3'd3,
    KIND_IGNORED   = 3'd4,
    KIND_LOGON     = 3'd5,
    KIND_PROBLEM   = 3'd6
  } kind_e;

  // header and body constants
  localparam logic [7:0]  HeaderMagic  = 8'd114;
  localparam logic [7:0]  HeaderZero   = 8'd0;
  localparam logic [2:0]  HeaderBytes  = 3'd6;
  localparam logic [31:0] LogonLength  = 32'd5;
  localparam logic [2:0]  LogonDone    = 3'd5;
  localparam logic [2:0]  LogonFail    = 3'd7;
  localparam logic [31:0] ProblemCode  = 32'hFFFF_FFFB;
  localparam logic [7:0]  CharUpperL   = 8'h4C;
  localparam logic [7:0]  CharLowerL   = 8'h6C;
  localparam logic [7:0]  CharO        = 8'h6F;
  localparam logic [7:0]  CharG        = 8'h67;
  localparam logic [7:0]  CharN        = 8'h6E;

  // input beat
  typedef struct packed {
    logic [7:0] channel;
    logic [7:0] frame_byte;
    logic       end_of_message;
  } in_t;

  // result beat
  typedef struct packed {
    logic [7:0]         channel_out;
    kind_e              kind;
    logic [7:0]         payload_byte;
    logic signed [31:0] error_value;
    logic               last_result;
  } out_t;

endpackage

// ===== design/message_frame_field_deframer.sv =====
// message frame field deframer: header check, body field walk, result queue
//
// Takes one message byte per beat and can accept a beat in every cycle while
// the result queue has room. Each beat updates the phase and counters in a
// single registered step and pushes up to two result beats (a subject, sender
// or content byte, then a status on the final byte) into a four-entry result
// queue. The queue drains one result per cycle while out_ready_i is high, so
// input is accepted whenever at least two entries are free: sustained rate is
// one byte per cycle while the output is ready; the final byte of a message
// that also emits a data byte pushes two results. After each final byte the
// parser returns to its header phase for the next message.
module message_frame_field_deframer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mffd_pkg::in_t in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mffd_pkg::out_t out_o
);

  // parser phases, one-hot
  typedef enum logic [11:0] {
    PH_HEADER    = 12'b0000_0000_0001,
    PH_ERR       = 12'b0000_0000_0010,
    PH_STAMP     = 12'b0000_0000_0100,
    PH_SUBJ_LEN  = 12'b0000_0000_1000,
    PH_SUBJ_DATA = 12'b0000_0001_0000,
    PH_SEND_LEN  = 12'b0000_0010_0000,
    PH_SEND_DATA = 12'b0000_0100_0000,
    PH_COUNT     = 12'b0000_1000_0000,
    PH_RCPT_LEN  = 12'b0001_0000_0000,
    PH_RCPT_DATA = 12'b0010_0000_0000,
    PH_CONTENT   = 12'b0100_0000_0000,
    PH_DONE      = 12'b1000_0000_0000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  byte_idx_q, byte_idx_d;
  logic [2:0]  hdr_seen_q, hdr_seen_d;
  logic [31:0] body_len_q, body_len_d;
  logic [31:0] body_rem_q, body_rem_d;
  logic [31:0] chunk_rem_q, chunk_rem_d;
  logic [31:0] rcpt_left_q, rcpt_left_d;
  logic [23:0] word_q, word_d;
  logic [31:0] err_held_q, err_held_d;
  logic        pad_q, pad_d;
  logic [2:0]  logon_q, logon_d;
  logic        hdr_bad_q, hdr_bad_d;
  logic        problem_q, problem_d;

  logic        accept;
  logic [7:0]  b;
  logic [31:0] word_w;
  logic        done_req;
  phase_e      done_ph;
  logic        start_req;
  phase_e      start_ph;
  logic        emit_byte;
  mffd_pkg::kind_e byte_kind;
  mffd_pkg::kind_e stat_kind;
  logic [31:0] stat_err;
  logic [31:0] rcpt_dec;

  assign accept = in_valid_i && in_ready_o;
  assign b      = in_i.frame_byte;
  assign word_w = {word_q, b};
  assign rcpt_dec = rcpt_left_q - 32'd1;

  // per-byte parser step
  always_comb begin
    phase_d     = phase_q;
    byte_idx_d  = byte_idx_q;
    hdr_seen_d  = hdr_seen_q;
    body_len_d  = body_len_q;
    body_rem_d  = body_rem_q;
    chunk_rem_d = chunk_rem_q;
    rcpt_left_d = rcpt_left_q;
    word_d      = word_q;
    err_held_d  = err_held_q;
    pad_d       = pad_q;
    logon_d     = logon_q;
    hdr_bad_d   = hdr_bad_q;
    problem_d   = problem_q;
    done_req    = 1'b0;
    done_ph     = phase_q;
    start_req   = 1'b0;
    start_ph    = phase_q;
    emit_byte   = 1'b0;
    byte_kind   = mffd_pkg::KIND_CONTENT;

    if (phase_q == PH_HEADER) begin
      // header bytes: magic, zero, 32-bit length
      if (hdr_seen_q == 3'd0 && b != mffd_pkg::HeaderMagic) begin
        hdr_bad_d = 1'b1;
      end else if (hdr_seen_q == 3'd1 && b != mffd_pkg::HeaderZero) begin
        hdr_bad_d = 1'b1;
      end else if (hdr_seen_q >= 3'd2) begin
        body_len_d = {body_len_q[23:0], b};
      end
      hdr_seen_d = hdr_seen_q + 3'd1;
      if (hdr_seen_d >= mffd_pkg::HeaderBytes) begin
        if (body_len_d[31]) begin
          hdr_bad_d = 1'b1;
        end
        if (hdr_bad_d) begin
          body_rem_d = '0;
          phase_d    = PH_DONE;
        end else begin
          body_rem_d = body_len_d;
          phase_d    = PH_ERR;
          byte_idx_d = '0;
          word_d     = '0;
        end
      end
    end else if (body_rem_q != '0) begin
      body_rem_d = body_rem_q - 32'd1;
      unique case (phase_q)
        // chunk data and pad bytes
        PH_SUBJ_DATA, PH_SEND_DATA, PH_RCPT_DATA: begin
          if (chunk_rem_q != '0) begin
            if (phase_q == PH_SUBJ_DATA) begin
              emit_byte = 1'b1;
              byte_kind = mffd_pkg::KIND_SUBJECT;
              if (logon_q < mffd_pkg::LogonDone) begin
                logon_d = mffd_pkg::LogonFail;
                unique case (logon_q)
                  3'd0: if (b == mffd_pkg::CharUpperL || b == mffd_pkg::CharLowerL)
                          logon_d = 3'd1;
                  3'd1: if (b == mffd_pkg::CharO) logon_d = 3'd2;
                  3'd2: if (b == mffd_pkg::CharG) logon_d = 3'd3;
                  3'd3: if (b == mffd_pkg::CharO) logon_d = 3'd4;
                  3'd4: if (b == mffd_pkg::CharN) logon_d = 3'd5;
                  default: logon_d = mffd_pkg::LogonFail;
                endcase
              end
            end else if (phase_q == PH_SEND_DATA) begin
              emit_byte = 1'b1;
              byte_kind = mffd_pkg::KIND_SENDER;
            end
            chunk_rem_d = chunk_rem_q - 32'd1;
            if (chunk_rem_d == '0 && !pad_q) begin
              done_req = 1'b1;
            end
          end else begin
            pad_d    = 1'b0;
            done_req = 1'b1;
          end
        end
        PH_CONTENT: begin
          emit_byte = 1'b1;
          byte_kind = mffd_pkg::KIND_CONTENT;
        end
        // 32-bit word fields
        PH_ERR, PH_STAMP, PH_SUBJ_LEN, PH_SEND_LEN, PH_COUNT, PH_RCPT_LEN: begin
          word_d     = word_w[23:0];
          byte_idx_d = byte_idx_q + 2'd1;
          if (byte_idx_q == 2'd3) begin
            byte_idx_d = '0;
            word_d     = '0;
            unique case (phase_q)
              PH_ERR: begin
                err_held_d = word_w;
                phase_d    = PH_STAMP;
              end
              PH_STAMP: phase_d = PH_SUBJ_LEN;
              PH_SUBJ_LEN: begin
                logon_d   = (word_w == mffd_pkg::LogonLength) ? 3'd0
                                                              : mffd_pkg::LogonFail;
                start_req = 1'b1;
                start_ph  = PH_SUBJ_DATA;
              end
              PH_SEND_LEN: begin
                start_req = 1'b1;
                start_ph  = PH_SEND_DATA;
              end
              PH_COUNT: begin
                if (word_w[31]) begin
                  problem_d = 1'b1;
                  phase_d   = PH_DONE;
                end else begin
                  rcpt_left_d = word_w;
                  phase_d     = (word_w != '0) ? PH_RCPT_LEN : PH_CONTENT;
                end
              end
              default: begin
                start_req = 1'b1;
                start_ph  = PH_RCPT_DATA;
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end

    // chunk start from a length word
    if (start_req) begin
      if (word_w[31]) begin
        problem_d = 1'b1;
        phase_d   = PH_DONE;
      end else begin
        chunk_rem_d = word_w;
        pad_d       = word_w[0];
        phase_d     = start_ph;
        if (word_w == '0) begin
          done_req = 1'b1;
          done_ph  = start_ph;
        end
      end
    end

    // chunk end: move to the next field
    if (done_req) begin
      priority if (done_ph == PH_SUBJ_DATA) begin
        phase_d = PH_SEND_LEN;
      end else if (done_ph == PH_SEND_DATA) begin
        phase_d = PH_COUNT;
      end else begin
        rcpt_left_d = rcpt_dec;
        phase_d     = (rcpt_dec != '0) ? PH_RCPT_LEN : PH_CONTENT;
      end
    end

    // status on the final byte, from the updated state
    stat_err = '0;
    priority if (phase_d == PH_HEADER || hdr_bad_d || body_rem_d != '0) begin
      stat_kind = mffd_pkg::KIND_IGNORED;
    end else if (problem_d || phase_d != PH_CONTENT) begin
      stat_kind = mffd_pkg::KIND_PROBLEM;
      stat_err  = mffd_pkg::ProblemCode;
    end else if (logon_d == mffd_pkg::LogonDone) begin
      stat_kind = mffd_pkg::KIND_LOGON;
    end else begin
      stat_kind = mffd_pkg::KIND_DELIVERED;
      stat_err  = err_held_d;
    end

    // back to the header phase after the final byte
    if (in_i.end_of_message) begin
      phase_d     = PH_HEADER;
      byte_idx_d  = '0;
      hdr_seen_d  = '0;
      body_len_d  = '0;
      body_rem_d  = '0;
      chunk_rem_d = '0;
      rcpt_left_d = '0;
      word_d      = '0;
      err_held_d  = '0;
      pad_d       = 1'b0;
      logon_d     = '0;
      hdr_bad_d   = 1'b0;
      problem_d   = 1'b0;
    end
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      byte_idx_q  <= '0;
      hdr_seen_q  <= '0;
      body_len_q  <= '0;
      body_rem_q  <= '0;
      chunk_rem_q <= '0;
      rcpt_left_q <= '0;
      word_q      <= '0;
      err_held_q  <= '0;
      pad_q       <= 1'b0;
      logon_q     <= '0;
      hdr_bad_q   <= 1'b0;
      problem_q   <= 1'b0;
    end else if (accept) begin
      phase_q     <= phase_d;
      byte_idx_q  <= byte_idx_d;
      hdr_seen_q  <= hdr_seen_d;
      body_len_q  <= body_len_d;
      body_rem_q  <= body_rem_d;
      chunk_rem_q <= chunk_rem_d;
      rcpt_left_q <= rcpt_left_d;
      word_q      <= word_d;
      err_held_q  <= err_held_d;
      pad_q       <= pad_d;
      logon_q     <= logon_d;
      hdr_bad_q   <= hdr_bad_d;
      problem_q   <= problem_d;
    end
  end

  // result beats for this byte
  mffd_pkg::out_t res_byte, res_stat, push0, push1;
  logic           push0_en, push1_en;

  always_comb begin
    res_byte.channel_out  = in_i.channel;
    res_byte.kind         = byte_kind;
    res_byte.payload_byte = b;
    res_byte.error_value  = '0;
    res_byte.last_result  = 1'b0;

    res_stat.channel_out  = in_i.channel;
    res_stat.kind         = stat_kind;
    res_stat.payload_byte = '0;
    res_stat.error_value  = $signed(stat_err);
    res_stat.last_result  = 1'b1;

    push0    = emit_byte ? res_byte : res_stat;
    push1    = res_stat;
    push0_en = accept && (emit_byte || in_i.end_of_message);
    push1_en = accept && emit_byte && in_i.end_of_message;
  end

  // result queue
  mffd_pkg::out_t q_mem [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] count_q;
  logic       pop;
  logic [1:0] wr_next;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = count_q != 3'd0;
  assign out_o       = q_mem[rd_ptr_q];
  assign in_ready_o  = count_q <= 3'd2;
  assign wr_next     = wr_ptr_q + 2'd1;

  always_ff @(posedge clk_i) begin
    if (push0_en) begin
      q_mem[wr_ptr_q] <= push0;
    end
    if (push1_en) begin
      q_mem[wr_next] <= push1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + {1'b0, push0_en} + {1'b0, push1_en};
      rd_ptr_q <= rd_ptr_q + {1'b0, pop};
      count_q  <= count_q + {2'b0, push0_en} + {2'b0, push1_en} - {2'b0, pop};
    end
  end

endmodule
